### rtl/dsts_pkg.sv
package dsts_pkg;

    localparam int MAX_CHARS_DEF = 128;
    localparam int KEEP_DIGITS   = 6;
    localparam int MANT_DIGITS   = 5;
    localparam int EXP_MAX       = 127;

    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_POINT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [3:0] ROUND_DIGIT = 4'd5;
    localparam logic [3:0] DIGIT_NINE  = 4'd9;

    typedef logic [3:0] bcd_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic       negative;
        logic [3:0] digit_lead;
        logic [3:0] digit_first;
        logic [3:0] digit_second;
        logic [3:0] digit_third;
        logic [3:0] digit_fourth;
        logic       exp_negative;
        logic [6:0] exp_magnitude;
    } out_item_t;

    // scan state of the number being read, apart from the positions
    typedef struct packed {
        logic                        minus_seen;
        logic                        point_seen;
        logic                        significant_seen;
        logic [2:0]                  digits_kept;
        bcd_t [KEEP_DIGITS-1:0]      digit_store;
    } scan_flags_t;

endpackage

### rtl/decimal_string_to_scientific.sv
// Converts an ASCII decimal number, streamed one character per request
// ('-' only before the first digit or point, digits, at most one '.'; other bytes are
// ignored), into d.dddd x 10^e with five significant digits rounded half-up
// on the sixth. A number whose digits are all zero gives 0.0000 x 10^0 with
// the sign still taken from the minus. The block takes one character request
// every cycle while no last character is held back. A character sits in the
// input register, where the scan state and the rounding logic see it, and the
// result of the character marked last is registered from there into the result
// register. A character waits in the input register only while it is the
// last of a number and the previous result has not been taken.
module decimal_string_to_scientific import dsts_pkg::*; #(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int POS_W = $clog2(MAX_CHARS);

    // input register
    logic     in_valid_reg;
    in_item_t in_reg;

    // result register
    logic      out_valid_reg;
    out_item_t out_reg;

    logic             advance;
    scan_flags_t      flags_next;
    logic [POS_W-1:0] char_pos_next;
    logic [POS_W-1:0] point_pos_next;
    logic [POS_W-1:0] sig_pos_next;
    out_item_t        result;

    // a plain character never waits; a last one waits for a free result slot
    assign advance = in_valid_reg && (!in_reg.last_char || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    // scan state, updated by the character in the input register
    dsts_scan #(
        .MAX_CHARS (MAX_CHARS),
        .POS_W     (POS_W)
    ) u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .take           (advance),
        .item           (in_reg),
        .flags_next     (flags_next),
        .char_pos_next  (char_pos_next),
        .point_pos_next (point_pos_next),
        .sig_pos_next   (sig_pos_next)
    );

    // rounding and exponent from the state including the current character
    dsts_round #(
        .POS_W (POS_W)
    ) u_round (
        .flags     (flags_next),
        .char_pos  (char_pos_next),
        .point_pos (point_pos_next),
        .sig_pos   (sig_pos_next),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_reg.last_char) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_reg.last_char) begin
            out_reg <= result;
        end
    end

endmodule

### rtl/dsts_scan.sv
module dsts_scan import dsts_pkg::*; #(
    parameter int MAX_CHARS = MAX_CHARS_DEF,
    parameter int POS_W     = $clog2(MAX_CHARS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  in_item_t          item,
    output scan_flags_t       flags_next,
    output logic [POS_W-1:0]  char_pos_next,
    output logic [POS_W-1:0]  point_pos_next,
    output logic [POS_W-1:0]  sig_pos_next
);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_CHARS - 1);

    scan_flags_t      flags_reg;
    logic [POS_W-1:0] char_pos_reg;
    logic [POS_W-1:0] point_pos_reg;
    logic [POS_W-1:0] sig_pos_reg;

    logic       is_digit;
    logic [3:0] digit;
    logic       step_pos;

    always_comb begin
        is_digit       = (item.character >= CHAR_ZERO) && (item.character <= CHAR_NINE);
        digit          = 4'(item.character - CHAR_ZERO);
        flags_next     = flags_reg;
        point_pos_next = point_pos_reg;
        sig_pos_next   = sig_pos_reg;
        step_pos       = 1'b0;

        if (item.character == CHAR_MINUS) begin
            if (char_pos_reg == '0) begin
                flags_next.minus_seen = 1'b1;
            end
        end else if (item.character == CHAR_POINT) begin
            if (!flags_reg.point_seen) begin
                flags_next.point_seen = 1'b1;
                point_pos_next        = char_pos_reg;
                step_pos              = 1'b1;
            end
        end else if (is_digit) begin
            step_pos = 1'b1;
            if (!flags_reg.significant_seen && digit != 4'd0) begin
                flags_next.significant_seen = 1'b1;
                sig_pos_next                = char_pos_reg;
            end
            if (flags_next.significant_seen && flags_reg.digits_kept < 3'(KEEP_DIGITS)) begin
                flags_next.digit_store[flags_reg.digits_kept] = digit;
                flags_next.digits_kept = flags_reg.digits_kept + 3'd1;
            end
        end

        // position saturates on long input
        if (step_pos && char_pos_reg != POS_LAST) begin
            char_pos_next = char_pos_reg + POS_W'(1);
        end else begin
            char_pos_next = char_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg     <= '0;
            char_pos_reg  <= '0;
            point_pos_reg <= '0;
            sig_pos_reg   <= '0;
        end else if (take) begin
            if (item.last_char) begin
                flags_reg     <= '0;
                char_pos_reg  <= '0;
                point_pos_reg <= '0;
                sig_pos_reg   <= '0;
            end else begin
                flags_reg     <= flags_next;
                char_pos_reg  <= char_pos_next;
                point_pos_reg <= point_pos_next;
                sig_pos_reg   <= sig_pos_next;
            end
        end
    end

endmodule

### rtl/dsts_round.sv
module dsts_round import dsts_pkg::*; #(
    parameter int POS_W = $clog2(MAX_CHARS_DEF)
) (
    input  scan_flags_t      flags,
    input  logic [POS_W-1:0] char_pos,
    input  logic [POS_W-1:0] point_pos,
    input  logic [POS_W-1:0] sig_pos,
    output out_item_t        result
);

    localparam int EXP_W = POS_W + 2;
    localparam int MAG_W = (EXP_W > 8) ? EXP_W : 8;
    localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(EXP_MAX);

    bcd_t [MANT_DIGITS-1:0]  mant;
    logic                    carry;
    logic signed [EXP_W-1:0] pt;
    logic signed [EXP_W-1:0] sg;
    logic signed [EXP_W-1:0] expo;
    logic [EXP_W-1:0]        mag;
    logic [MAG_W-1:0]        mag_wide;
    logic [6:0]              mag_sat;

    always_comb begin
        pt = flags.point_seen ? EXP_W'(point_pos) : EXP_W'(char_pos);
        sg = EXP_W'(sig_pos);
        for (int i = 0; i < MANT_DIGITS; i++) begin
            mant[i] = flags.digit_store[i];
        end
        expo  = (sg < pt) ? (pt - sg - EXP_W'(1)) : (pt - sg);
        carry = flags.digit_store[MANT_DIGITS] >= ROUND_DIGIT;

        // half-up rounding, carry ripples from the last kept digit
        for (int i = MANT_DIGITS - 1; i >= 0; i--) begin
            if (carry) begin
                if (mant[i] >= DIGIT_NINE) begin
                    mant[i] = 4'd0;
                end else begin
                    mant[i] = mant[i] + 4'd1;
                    carry   = 1'b0;
                end
            end
        end
        if (carry) begin
            mant    = '0;
            mant[0] = 4'd1;
            expo    = expo + EXP_W'(1);
        end

        if (!flags.significant_seen) begin
            mant = '0;
            expo = '0;
        end

        mag      = expo[EXP_W-1] ? EXP_W'(-expo) : EXP_W'(expo);
        mag_wide = MAG_W'(mag);
        mag_sat  = (mag_wide > MAG_MAX) ? 7'(EXP_MAX) : mag_wide[6:0];

        result.negative      = flags.minus_seen;
        result.digit_lead    = mant[0];
        result.digit_first   = mant[1];
        result.digit_second  = mant[2];
        result.digit_third   = mant[3];
        result.digit_fourth  = mant[4];
        result.exp_negative  = expo[EXP_W-1];
        result.exp_magnitude = mag_sat;
    end

endmodule

### rtl/dsts_check.sv
module dsts_check import dsts_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // mantissa digits are decimal
    a_bcd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.digit_lead <= 4'd9 && m_data.digit_first <= 4'd9
                 && m_data.digit_second <= 4'd9 && m_data.digit_third <= 4'd9
                 && m_data.digit_fourth <= 4'd9)
        else $error("mantissa digit out of range");

    // zero exponent is never negative
    a_exp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.exp_magnitude == 7'd0 |-> !m_data.exp_negative)
        else $error("negative zero exponent");

    // a zero lead digit only comes with the all-zero result
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.digit_lead == 4'd0 |->
            m_data.digit_first == 4'd0 && m_data.digit_second == 4'd0
            && m_data.digit_third == 4'd0 && m_data.digit_fourth == 4'd0
            && m_data.exp_magnitude == 7'd0)
        else $error("zero lead digit with nonzero result");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind decimal_string_to_scientific dsts_check u_check (.*);

### test/decimal_string_to_scientific_tb.sv
module decimal_string_to_scientific_tb;
    import dsts_pkg::*;

    // predicts the scientific form of each streamed number and checks results in order
    class sci_predictor;
        int unsigned char_pos;
        int unsigned point_pos;
        int unsigned sig_pos;
        int unsigned kept;
        bit          point_seen;
        bit          sig_seen;
        bit          minus_seen;
        bcd_t        digits[KEEP_DIGITS];
        out_item_t   pending_results[$];
        int unsigned n_chars;
        int unsigned n_numbers;
        int unsigned n_checked;
        int unsigned n_carries;
        int unsigned n_zeros;
        int unsigned n_errors;

        function new();
            clear_number();
        endfunction

        function void clear_number();
            char_pos   = 0;
            point_pos  = 0;
            sig_pos    = 0;
            kept       = 0;
            point_seen = 1'b0;
            sig_seen   = 1'b0;
            minus_seen = 1'b0;
            foreach (digits[i]) digits[i] = '0;
        endfunction

        function void advance();
            if (char_pos < MAX_CHARS_DEF - 1) char_pos++;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void note_char(in_item_t req);
            bcd_t      d;
            bcd_t      mant[MANT_DIGITS];
            int        pt;
            int        sg;
            int        e;
            bit        carry;
            out_item_t res;
            n_chars++;
            if (req.character == CHAR_MINUS) begin
                if (char_pos == 0 && !minus_seen) minus_seen = 1'b1;
            end else if (req.character == CHAR_POINT) begin
                if (!point_seen) begin
                    point_seen = 1'b1;
                    point_pos  = char_pos;
                    advance();
                end
            end else if (req.character >= CHAR_ZERO && req.character <= CHAR_NINE) begin
                d = bcd_t'(req.character - CHAR_ZERO);
                if (!sig_seen && d != 0) begin
                    sig_seen = 1'b1;
                    sig_pos  = char_pos;
                end
                if (sig_seen && kept < KEEP_DIGITS) begin
                    digits[kept] = d;
                    kept++;
                end
                advance();
            end
            if (!req.last_char) return;

            foreach (mant[i]) mant[i] = '0;
            e = 0;
            if (sig_seen) begin
                pt = point_seen ? int'(point_pos) : int'(char_pos);
                sg = int'(sig_pos);
                for (int i = 0; i < MANT_DIGITS; i++) mant[i] = digits[i];
                e = (sg < pt) ? pt - sg - 1 : pt - sg;
                carry = 1'b0;
                if (digits[KEEP_DIGITS-1] >= ROUND_DIGIT) begin
                    carry = 1'b1;
                    for (int i = MANT_DIGITS - 1; i >= 0 && carry; i--) begin
                        if (mant[i] >= DIGIT_NINE) begin
                            mant[i] = '0;
                        end else begin
                            mant[i] = mant[i] + 1'b1;
                            carry   = 1'b0;
                        end
                    end
                end
                if (carry) begin
                    foreach (mant[i]) mant[i] = '0;
                    mant[0] = 4'd1;
                    e++;
                    n_carries++;
                end
            end else begin
                n_zeros++;
            end

            res              = '0;
            res.negative     = minus_seen;
            res.digit_lead   = mant[0];
            res.digit_first  = mant[1];
            res.digit_second = mant[2];
            res.digit_third  = mant[3];
            res.digit_fourth = mant[4];
            if (e < 0) begin
                res.exp_negative  = 1'b1;
                res.exp_magnitude = (-e > EXP_MAX) ? 7'(EXP_MAX) : 7'(-e);
            end else begin
                res.exp_negative  = 1'b0;
                res.exp_magnitude = (e > EXP_MAX) ? 7'(EXP_MAX) : 7'(e);
            end
            pending_results.push_back(res);
            n_numbers++;
            clear_number();
        endfunction

        function void check_field(string name, logic [6:0] want, logic [6:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            n_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                n_errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("negative", 7'(want.negative), 7'(got.negative));
            check_field("digit_lead", 7'(want.digit_lead), 7'(got.digit_lead));
            check_field("digit_first", 7'(want.digit_first), 7'(got.digit_first));
            check_field("digit_second", 7'(want.digit_second), 7'(got.digit_second));
            check_field("digit_third", 7'(want.digit_third), 7'(got.digit_third));
            check_field("digit_fourth", 7'(want.digit_fourth), 7'(got.digit_fourth));
            check_field("exp_negative", 7'(want.exp_negative), 7'(got.exp_negative));
            check_field("exp_magnitude", want.exp_magnitude, got.exp_magnitude);
        endfunction
    endclass

    // clock, reset and block ports; the driven ones are known from time zero
    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    sci_predictor sb = new();

    // idle controls: sender gaps and receiver stalls switch on and off in stretches
    bit          send_gaps   = 1'b1;
    bit          sink_stalls = 1'b1;
    int          stall_left  = 0;
    int unsigned n_sent      = 0;

    decimal_string_to_scientific i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // mostly short idle runs, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // digit character, leaning on zeros and, for carry hunting, on nines
    function automatic logic [7:0] rand_digit(bit nines);
        if (nines && $urandom_range(0, 9) != 0) return CHAR_NINE;
        if ($urandom_range(0, 99) < 15) return CHAR_ZERO;
        return 8'(CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    // requests and results are both sampled at the clock edge, before any update
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_char(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if ($urandom_range(0, 299) == 0) sink_stalls = !sink_stalls;
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 99) < 35) begin
            stall_left = idle_len() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one character request; returns right after the edge that accepts it
    task automatic send_item(in_item_t req);
        int gap;
        gap = (send_gaps && $urandom_range(0, 99) < 40) ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    // a whole number, last flag on its final character
    task automatic send_number(logic [7:0] txt[$]);
        in_item_t req;
        foreach (txt[i]) begin
            req.character = txt[i];
            req.last_char = (i == txt.size() - 1);
            send_item(req);
        end
    endtask

    task automatic send_text(string s);
        logic [7:0] txt[$];
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        send_number(txt);
    endtask

    // hold the sender off until every pending result is back; the check is made
    // at the falling edge so the monitor has already booked the last request
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // random number: mostly well-formed with random content, some noise and long runs
    task automatic random_number();
        logic [7:0] txt[$];
        int         kind;
        int         n;
        int         pos;
        bit         nines;
        kind = $urandom_range(0, 99);
        if (kind < 2) begin
            // long inputs, in either form, push the positions into saturation at the longer lengths
            n = $urandom_range(120, 140);
            if ($urandom_range(0, 1)) begin
                txt.push_back(CHAR_POINT);
                repeat (n) txt.push_back(CHAR_ZERO);
                repeat (3) txt.push_back(8'(CHAR_ZERO + $urandom_range(1, 9)));
            end else begin
                repeat (n) txt.push_back(8'(CHAR_ZERO + $urandom_range(1, 9)));
            end
        end else if (kind < 12) begin
            // raw bytes, any value
            n = $urandom_range(1, 6);
            repeat (n) txt.push_back(8'($urandom_range(0, 255)));
        end else begin
            nines = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 1)) txt.push_back(CHAR_MINUS);
            repeat ($urandom_range(0, 6)) txt.push_back(rand_digit(nines));
            if ($urandom_range(0, 2) != 0) begin
                txt.push_back(CHAR_POINT);
                repeat ($urandom_range(0, 8)) txt.push_back(rand_digit(nines));
            end
            if (txt.size() == 0) txt.push_back(rand_digit(nines));
            // occasionally break the sequence with a stray minus, point or byte
            if ($urandom_range(0, 9) == 0) begin
                pos = $urandom_range(0, txt.size());
                case ($urandom_range(0, 2))
                    0:       txt.insert(pos, CHAR_MINUS);
                    1:       txt.insert(pos, CHAR_POINT);
                    default: txt.insert(pos, 8'($urandom_range(0, 255)));
                endcase
            end
        end
        send_number(txt);
    endtask

    initial begin
        in_item_t    req;
        int unsigned random_start;
        bit          drained_once;
        drained_once = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero values, stray minus and second point, carries both ways
        send_text("0");
        send_text("-.00");
        send_text("1.2.-3");
        send_text("999995");
        send_text(".0999995");
        // byte extremes, ignored but still able to close a number
        req.character = CHAR_ZERO + 8'd1;
        req.last_char = 1'b0;
        send_item(req);
        req.character = 8'hFF;
        req.last_char = 1'b1;
        send_item(req);
        req.character = 8'h00;
        req.last_char = 1'b1;
        send_item(req);

        // let everything come back before the random part
        wait_drained();

        // random part, opening with a stretch at full rate
        send_gaps    = 1'b0;
        random_start = n_sent;
        while (n_sent - random_start < 600) begin
            if (!drained_once && n_sent - random_start >= 300) begin
                wait_drained();
                drained_once = 1'b1;
            end
            if ($urandom_range(0, 19) == 0) send_gaps = !send_gaps;
            random_number();
        end

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("covered %0d numbers from %0d characters, %0d results checked",
                 sb.n_numbers, sb.n_chars, sb.n_checked);
        $display("rounding carries: %0d, all-zero values: %0d, mismatches: %0d",
                 sb.n_carries, sb.n_zeros, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("decimal_string_to_scientific verification clean");
        end else begin
            $display("decimal_string_to_scientific verification failed");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #3000000;
        $display("decimal_string_to_scientific verification failed");
        $finish;
    end

endmodule
